/* rtl/sst_pkg.sv */
package sst_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int IDX_W     = 6;
	localparam int CAP_W     = 5;
	localparam int CNT_OUT_W = 5;
	localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_REMOVE   = 2'd1,
		CMD_CONTAINS = 2'd2,
		CMD_READ     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_DUP    = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DECIDE,
		S_UP_RD,
		S_UP_WR,
		S_DN_RD,
		S_DN_WR,
		S_RD_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic                    found;
		logic [CNT_OUT_W-1:0]    count;
		status_t                 status;
	} res_t;

endpackage

/* rtl/sorted_set_table_top.sv */
// channel | signals                                      | role
// in      | in_valid, in_ready, cmd, value, index        | command transaction
// out     | out_valid, out_ready, read_value, found,     | result transaction
//         | count, status                                |
// cfg     | cfg_valid, cfg_ready, cfg_data               | capacity write
//
// One command at a time, paced by the element memory's registered read: each passes
// idle, decide and hand-off; search reads each entry below the value, stopping at the
// set's end or the first entry not below it; insert shifts entries above it up, writes
// the value; remove shifts later entries down; read-at-index reads one entry if below
// the count. Reset clears the count and sets capacity to 16; elements are not cleared.
// A stalled out_ready holds one result; the next command is taken meanwhile.
module sorted_set_table_top
	import sst_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              cmd,
	input  logic signed [VAL_W-1:0] value,
	input  logic [IDX_W-1:0]        index,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] read_value,
	output logic                    found,
	output logic [CNT_OUT_W-1:0]    count,
	output logic [1:0]              status,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CAP_W-1:0]        cfg_data
);

	logic [CAP_W-1:0] cap_q;
	logic eng_ready, res_valid, res_take;
	res_t eng_res;
	logic out_valid_q;
	res_t out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	sst_engine #(
		.DEPTH(DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap       (cap_q),
		.start     (in_valid),
		.ready     (eng_ready),
		.cmd       (cmd_t'(cmd)),
		.value     (value),
		.idx       (index),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (eng_res)
	);

	assign in_ready = eng_ready;
	// load the output slot when it is empty or being drained
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= eng_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_q.read_value;
	assign found      = out_q.found;
	assign count      = out_q.count;
	assign status     = out_q.status;

`ifndef SYNTHESIS
	a_idle_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(eng_ready && res_valid))
		else $error("engine idle and done at once");

	a_dup_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && eng_res.status == ST_DUP |=> out_valid && found)
		else $error("duplicate insert without found");

	a_full_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && eng_res.status == ST_FULL |-> eng_res.read_value == '0)
		else $error("refused insert carries read data");

	a_slot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_q))
		else $error("pending result lost");
`endif

endmodule

/* rtl/sst_engine.sv */
module sst_engine
	import sst_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [CAP_W-1:0]        cap,
	input  logic                    start,
	output logic                    ready,
	input  cmd_t                    cmd,
	input  logic signed [VAL_W-1:0] value,
	input  logic [IDX_W-1:0]        idx,
	output logic                    res_valid,
	input  logic                    res_take,
	output res_t                    res
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = (CW > CAP_W) ? CW : CAP_W;
	localparam int IW = (CW > IDX_W) ? CW : IDX_W;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] p_q, p_d;
	logic [CW-1:0] j_q, j_d;
	logic found_q, found_d;
	status_t status_q, status_d;
	logic signed [VAL_W-1:0] rdv_q, rdv_d;
	cmd_t cmd_q;
	logic signed [VAL_W-1:0] val_q;
	logic [IDX_W-1:0] idx_q;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rd_q;
	logic rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [VAL_W-1:0] wr_data;

	logic [KW-1:0] eff_cap;
	logic full, idx_hit;

	assign eff_cap = (KW'(cap) > KW'(DEPTH)) ? KW'(DEPTH) : KW'(cap);
	assign full    = KW'(cnt_q) >= eff_cap;
	assign idx_hit = IW'(idx_q) < IW'(cnt_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		p_d      = p_q;
		j_d      = j_q;
		found_d  = found_q;
		status_d = status_q;
		rdv_d    = rdv_q;
		rd_en    = 1'b0;
		rd_addr  = AW'(p_q);
		wr_en    = 1'b0;
		wr_addr  = AW'(j_q);
		wr_data  = rd_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					p_d      = '0;
					found_d  = 1'b0;
					status_d = ST_OK;
					rdv_d    = '0;
					state_d  = (cmd == CMD_READ) ? S_DECIDE : S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				if (p_q >= cnt_q) begin
					state_d = S_DECIDE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(p_q);
					state_d = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				// stop at the first entry not below the value
				if ($signed(rd_q) < val_q) begin
					p_d     = p_q + 1'b1;
					state_d = S_SRCH_RD;
				end else begin
					found_d = (rd_q == val_q);
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (cmd_q)
					CMD_INSERT: begin
						if (full) begin
							status_d = ST_FULL;
							state_d  = S_DONE;
						end else if (found_q) begin
							status_d = ST_DUP;
							state_d  = S_DONE;
						end else begin
							j_d     = cnt_q;
							state_d = S_UP_RD;
						end
					end
					CMD_REMOVE: begin
						if (found_q) begin
							j_d     = p_q;
							state_d = S_DN_RD;
						end else begin
							status_d = ST_ABSENT;
							state_d  = S_DONE;
						end
					end
					CMD_CONTAINS: begin
						status_d = found_q ? ST_OK : ST_ABSENT;
						state_d  = S_DONE;
					end
					default: begin
						if (idx_hit) begin
							rd_en   = 1'b1;
							rd_addr = AW'(idx_q);
							state_d = S_RD_WAIT;
						end else begin
							status_d = ST_ABSENT;
							state_d  = S_DONE;
						end
					end
				endcase
			end
			S_UP_RD: begin
				// walk down from the top, then drop the new value into the hole
				if (j_q == p_q) begin
					wr_en   = 1'b1;
					wr_addr = AW'(p_q);
					wr_data = val_q;
					cnt_d   = cnt_q + 1'b1;
					state_d = S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(j_q - 1'b1);
					state_d = S_UP_WR;
				end
			end
			S_UP_WR: begin
				wr_en   = 1'b1;
				wr_addr = AW'(j_q);
				wr_data = rd_q;
				j_d     = j_q - 1'b1;
				state_d = S_UP_RD;
			end
			S_DN_RD: begin
				if (CW'(j_q + 1'b1) >= cnt_q) begin
					cnt_d   = cnt_q - 1'b1;
					state_d = S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(j_q + 1'b1);
					state_d = S_DN_WR;
				end
			end
			S_DN_WR: begin
				wr_en   = 1'b1;
				wr_addr = AW'(j_q);
				wr_data = rd_q;
				j_d     = j_q + 1'b1;
				state_d = S_DN_RD;
			end
			S_RD_WAIT: begin
				rdv_d   = rd_q;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		p_q      <= p_d;
		j_q      <= j_d;
		found_q  <= found_d;
		status_q <= status_d;
		rdv_q    <= rdv_d;
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
			val_q <= value;
			idx_q <= idx;
		end
	end

	assign ready           = (state_q == S_IDLE);
	assign res_valid       = (state_q == S_DONE);
	assign res.read_value  = rdv_q;
	assign res.found       = found_q;
	assign res.count       = CNT_OUT_W'(cnt_q);
	assign res.status      = status_q;

endmodule

/* bench/sorted_set_table_top_tb.sv */
`timescale 1ns / 100ps

module sorted_set_table_top_tb;
	import sst_pkg::*;

	localparam int TBL_DEPTH = DEPTH_DEF;
	localparam int POOL_N = 24;
	localparam int PHASE_ITEMS = 188;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYC = 200;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;

	typedef struct {
		bit                      is_cfg;
		logic [CAP_W-1:0]        cap;
		cmd_t                    op;
		logic signed [VAL_W-1:0] val;
		logic [IDX_W-1:0]        idx;
		bit                      has_exp;
		res_t                    exp_res;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              cmd;
	logic signed [VAL_W-1:0] value;
	logic [IDX_W-1:0]        index;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [VAL_W-1:0] read_value;
	logic                    found;
	logic [CNT_OUT_W-1:0]    count;
	logic [1:0]              status;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CAP_W-1:0]        cfg_data;

	// sideband that travels with each command transaction
	bit   row_has_exp;
	res_t row_exp;

	// shadow copy of the set
	logic signed [VAL_W-1:0] set_mem [TBL_DEPTH];
	int                      set_cnt = 0;
	logic [CAP_W-1:0]        cap_q = CAP_RST;

	res_t pending_results [$];
	int   mismatches = 0;
	int   stall_cyc = 0;
	int   burst_left = 8;
	bit   hold_go = 1'b0;
	bit   hold_done = 1'b0;

	logic signed [VAL_W-1:0] val_pool [POOL_N];
	int                      pool_len = 1;

	sorted_set_table_top #(
		.DEPTH(TBL_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.value(value),
		.index(index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_value(read_value),
		.found(found),
		.count(count),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// apply one command to the shadow set and return the result it gives
	function automatic res_t predict_set_op(cmd_t op, logic signed [VAL_W-1:0] v,
			logic [IDX_W-1:0] ix);
		res_t r;
		int   pos;
		int   lim;
		int   j;
		r = '0;
		r.status = ST_OK;
		lim = (cap_q > TBL_DEPTH) ? TBL_DEPTH : int'(cap_q);
		if (op == CMD_READ) begin
			if (int'(ix) < set_cnt)
				r.read_value = set_mem[ix];
			else
				r.status = ST_ABSENT;
		end else begin
			pos = 0;
			while (pos < set_cnt && set_mem[pos] < v)
				pos++;
			r.found = (pos < set_cnt) && (set_mem[pos] == v);
			case (op)
				CMD_INSERT: begin
					if (set_cnt >= lim) begin
						r.status = ST_FULL;
					end else if (r.found) begin
						r.status = ST_DUP;
					end else begin
						for (j = set_cnt; j > pos; j--)
							set_mem[j] = set_mem[j-1];
						set_mem[pos] = v;
						set_cnt++;
					end
				end
				CMD_REMOVE: begin
					if (r.found) begin
						for (j = pos; j + 1 < set_cnt; j++)
							set_mem[j] = set_mem[j+1];
						set_cnt--;
					end else begin
						r.status = ST_ABSENT;
					end
				end
				default: begin
					if (!r.found)
						r.status = ST_ABSENT;
				end
			endcase
		end
		r.count = set_cnt[CNT_OUT_W-1:0];
		return r;
	endfunction

	task automatic check_field(string what, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : monitor
		res_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				cap_q = cfg_data;
			if (in_valid && in_ready) begin
				want = predict_set_op(cmd_t'(cmd), value, index);
				if (row_has_exp)
					want = row_exp;
				pending_results.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display({"%0t: result with nothing pending: ",
						"read_value %0d found %0d count %0d status %0d"},
						$time, read_value, found, count, status);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("read_value", want.read_value, read_value);
					check_field("found", want.found, found);
					check_field("count", want.count, count);
					check_field("status", want.status, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cyc <= 0;
		else
			stall_cyc <= stall_cyc + 1;
		if (stall_cyc >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random duty segments, one long hold-off on request
	initial begin
		int seg;
		int mode;
		int k;
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_go && !hold_done) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				mode = $urandom_range(0, 3);
				seg = $urandom_range(8, 80);
				for (k = 0; k < seg; k++) begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						2: out_ready <= ($urandom_range(0, 3) == 0);
						default: out_ready <= (k % 5 != 4);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	function automatic stim_row_t op_row(cmd_t op, logic signed [VAL_W-1:0] v,
			logic [IDX_W-1:0] ix);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.cap = '0;
		r.op = op;
		r.val = v;
		r.idx = ix;
		r.has_exp = 1'b0;
		r.exp_res = '0;
		return r;
	endfunction

	function automatic stim_row_t chk_row(cmd_t op, logic signed [VAL_W-1:0] v,
			logic [IDX_W-1:0] ix, logic signed [VAL_W-1:0] rv, logic f,
			logic [CNT_OUT_W-1:0] n, status_t st);
		stim_row_t r;
		r = op_row(op, v, ix);
		r.has_exp = 1'b1;
		r.exp_res.read_value = rv;
		r.exp_res.found = f;
		r.exp_res.count = n;
		r.exp_res.status = st;
		return r;
	endfunction

	function automatic stim_row_t cap_row(logic [CAP_W-1:0] c);
		stim_row_t r;
		r = op_row(CMD_READ, '0, '0);
		r.is_cfg = 1'b1;
		r.cap = c;
		return r;
	endfunction

	task automatic offer(cmd_t op, logic signed [VAL_W-1:0] v, logic [IDX_W-1:0] ix,
			bit typed, res_t ex);
		in_valid <= 1'b1;
		cmd <= op;
		value <= v;
		index <= ix;
		row_has_exp <= typed;
		row_exp <= ex;
		do @(posedge clk); while (!in_ready);
	endtask

	// end a burst by dropping valid for a random gap, else keep valid high
	task automatic pace();
		int gap;
		if (burst_left > 1) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] c);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random_phase(logic [CAP_W-1:0] c, bit with_hold);
		int                      k;
		int                      r;
		cmd_t                    op;
		logic signed [VAL_W-1:0] v;
		logic [IDX_W-1:0]        ix;
		write_capacity(c);
		// a small pool gives duplicates and hits on remove, a large one fills the set
		pool_len = $urandom_range(4, POOL_N);
		for (k = 0; k < POOL_N; k++) begin
			case ($urandom_range(0, 4))
				0: val_pool[k] = $urandom_range(0, 20) - 10;
				1: val_pool[k] = VAL_MIN + $urandom_range(0, 3);
				2: val_pool[k] = VAL_MAX - $urandom_range(0, 3);
				default: val_pool[k] = $urandom;
			endcase
		end
		if (with_hold)
			hold_go = 1'b1;
		for (k = 0; k < PHASE_ITEMS; k++) begin
			r = $urandom_range(0, 99);
			if (k < PHASE_ITEMS / 2)
				op = (r < 55) ? CMD_INSERT : (r < 70) ? CMD_REMOVE
					: (r < 85) ? CMD_CONTAINS : CMD_READ;
			else
				op = (r < 20) ? CMD_INSERT : (r < 60) ? CMD_REMOVE
					: (r < 80) ? CMD_CONTAINS : CMD_READ;
			v = ($urandom_range(0, 9) == 0) ? $urandom
				: val_pool[$urandom_range(0, pool_len - 1)];
			ix = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 63))
				: IDX_W'($urandom_range(0, 16));
			offer(op, v, ix, 1'b0, '0);
			pace();
		end
	endtask

	initial begin
		stim_row_t dir_tbl [$];
		in_valid = 1'b0;
		cmd = CMD_INSERT;
		value = '0;
		index = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		row_has_exp = 1'b0;
		row_exp = '0;

		dir_tbl.push_back(chk_row(CMD_READ, 0, 0, 0, 1'b0, 0, ST_ABSENT));
		dir_tbl.push_back(chk_row(CMD_REMOVE, 5, 0, 0, 1'b0, 0, ST_ABSENT));
		dir_tbl.push_back(chk_row(CMD_INSERT, VAL_MAX, 0, 0, 1'b0, 1, ST_OK));
		dir_tbl.push_back(chk_row(CMD_INSERT, VAL_MIN, 0, 0, 1'b0, 2, ST_OK));
		dir_tbl.push_back(op_row(CMD_INSERT, 0, 63));
		dir_tbl.push_back(op_row(CMD_INSERT, -1, 0));
		dir_tbl.push_back(chk_row(CMD_INSERT, 0, 0, 0, 1'b1, 4, ST_DUP));
		dir_tbl.push_back(chk_row(CMD_READ, 0, 0, VAL_MIN, 1'b0, 4, ST_OK));
		dir_tbl.push_back(chk_row(CMD_READ, 0, 3, VAL_MAX, 1'b0, 4, ST_OK));
		dir_tbl.push_back(chk_row(CMD_READ, 0, 4, 0, 1'b0, 4, ST_ABSENT));
		dir_tbl.push_back(chk_row(CMD_READ, VAL_MAX, 63, 0, 1'b0, 4, ST_ABSENT));
		dir_tbl.push_back(op_row(CMD_CONTAINS, -1, 0));
		dir_tbl.push_back(op_row(CMD_CONTAINS, 1, 0));
		dir_tbl.push_back(op_row(CMD_REMOVE, VAL_MIN, 0));
		dir_tbl.push_back(chk_row(CMD_REMOVE, VAL_MIN, 0, 0, 1'b0, 3, ST_ABSENT));
		// lower capacity to the current count: inserts refused, duplicate too
		dir_tbl.push_back(cap_row(3));
		dir_tbl.push_back(chk_row(CMD_INSERT, 0, 0, 0, 1'b1, 3, ST_FULL));
		dir_tbl.push_back(chk_row(CMD_INSERT, 7, 0, 0, 1'b0, 3, ST_FULL));
		dir_tbl.push_back(op_row(CMD_REMOVE, 0, 0));
		dir_tbl.push_back(op_row(CMD_INSERT, 32'sh55555555, 42));
		dir_tbl.push_back(cap_row(0));
		dir_tbl.push_back(chk_row(CMD_INSERT, 1, 0, 0, 1'b0, 3, ST_FULL));
		dir_tbl.push_back(op_row(CMD_CONTAINS, 32'sh55555555, 0));
		// above the table depth: clipped
		dir_tbl.push_back(cap_row(31));
		dir_tbl.push_back(op_row(CMD_INSERT, 32'shAAAAAAAA, 21));
		dir_tbl.push_back(op_row(CMD_READ, 0, 0));
		dir_tbl.push_back(op_row(CMD_READ, -1, 1));
		dir_tbl.push_back(op_row(CMD_REMOVE, VAL_MAX, 0));

		wait (arst_n);
		@(posedge clk);
		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].is_cfg) begin
				write_capacity(dir_tbl[i].cap);
			end else begin
				offer(dir_tbl[i].op, dir_tbl[i].val, dir_tbl[i].idx,
					dir_tbl[i].has_exp, dir_tbl[i].exp_res);
				pace();
			end
		end

		run_random_phase(5'd16, 1'b0);
		run_random_phase(5'd5, 1'b0);
		run_random_phase(5'd1, 1'b0);
		run_random_phase(5'd17, 1'b1);
		run_random_phase(5'd0, 1'b0);
		run_random_phase(5'd31, 1'b0);
		run_random_phase(5'd2, 1'b0);
		run_random_phase(5'd16, 1'b0);
		run_random_phase(5'd8, 1'b0);
		run_random_phase(5'd3, 1'b0);

		drain();
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
